[hdl/json_string_unescape_utf8_macros.svh]
// ----------------------------------------------------------------------------
// JSON string unescape assertion macros
// Shared concurrent check forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// same-cycle implication
`define JSU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("json unescape check failed");

// next-cycle implication
`define JSU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("json unescape check failed");

`endif

[hdl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// JSON string unescape package
// Parser modes, result kinds, character codes and the UTF-8 encoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_BODY   = 3'd1,
    MODE_ESC    = 3'd2,
    MODE_HEX1   = 3'd3,
    MODE_NEEDBS = 3'd4,
    MODE_NEEDU  = 3'd5,
    MODE_HEX2   = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  localparam logic [15:0] SURR_HI_MIN = 16'hD800;
  localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SURR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SURR_LO_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  typedef struct packed {
    logic [2:0]      num;
    logic [3:0][7:0] bytes;
  } enc_t;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic enc_t utf8_enc(input logic [20:0] cp);
    enc_t e;
    e.num   = 3'd0;
    e.bytes = '0;
    if (cp <= 21'h7F) begin
      e.num      = 3'd1;
      e.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      e.num      = 3'd2;
      e.bytes[0] = 8'hC0 | {3'b0, cp[10:6]};
      e.bytes[1] = 8'h80 | {2'b0, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      e.num      = 3'd3;
      e.bytes[0] = 8'hE0 | {4'b0, cp[15:12]};
      e.bytes[1] = 8'h80 | {2'b0, cp[11:6]};
      e.bytes[2] = 8'h80 | {2'b0, cp[5:0]};
    end else begin
      e.num      = 3'd4;
      e.bytes[0] = 8'hF0 | {5'b0, cp[20:18]};
      e.bytes[1] = 8'h80 | {2'b0, cp[17:12]};
      e.bytes[2] = 8'h80 | {2'b0, cp[11:6]};
      e.bytes[3] = 8'h80 | {2'b0, cp[5:0]};
    end
    return e;
  endfunction

endpackage

[hdl/json_string_unescape_utf8.sv]
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8
// Decodes a quoted JSON string byte by byte into UTF-8 bytes and a status.
// ----------------------------------------------------------------------------
// Input channel: one text byte per item (in_byte_i), or an end mark (text_end_i).
// Output channel: one result per item: a data byte, an ok status or an error
// status; last_o marks the final result caused by one input item.
// Parser state advances at input accept; all results of that item land in a
// result register group in the same edge and drain one per cycle unless stalled.
// The first result is valid in the cycle after its input is accepted.
// Throughput: one input item per cycle while each item makes at most one
// result and the receiver does not stall; an escape that yields an n-byte
// UTF-8 sequence holds the input while the result group drains.
// Items that make no result (opening quote, backslash, hex digits) never wait
// on the output side unless results are still pending.
// Reset: parser waits for an opening quote, result group is empty.
// Receiver stall: the current result holds; the input stalls once the last
// pending result cannot leave this cycle.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_macros.svh"

module json_string_unescape_utf8 (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       text_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       last_o
);

  jsu_pkg::mode_e  mode_q, mode_d;
  logic [15:0]     hex_q, hex_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [9:0]      high_q, high_d;

  logic [2:0]      rem_q, rem_d;
  logic [3:0][7:0] byte_q, byte_d;
  jsu_pkg::kind_e  kind_q, kind_d;

  logic            in_acc, out_take;
  logic [4:0]      hv;
  logic [15:0]     hex_new;
  logic            hex_done, is_hi, is_lo;
  logic [20:0]     pair_cp;
  jsu_pkg::enc_t   enc_bmp, enc_pair;

  logic [2:0]      res_num;
  logic [3:0][7:0] res_bytes;
  jsu_pkg::kind_e  res_kind;

  assign out_take   = out_valid_o && !out_stall_i;
  assign in_stall_o = (rem_q > 3'd1) || ((rem_q == 3'd1) && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign hv       = jsu_pkg::hex_val(in_byte_i);
  assign hex_new  = {hex_q[11:0], hv[3:0]};
  assign hex_done = hv[4] && (cnt_q == 2'd3);
  assign is_hi    = (hex_new >= jsu_pkg::SURR_HI_MIN) && (hex_new <= jsu_pkg::SURR_HI_MAX);
  assign is_lo    = (hex_new >= jsu_pkg::SURR_LO_MIN) && (hex_new <= jsu_pkg::SURR_LO_MAX);
  assign pair_cp  = jsu_pkg::SUPP_BASE + {1'b0, high_q, hex_new[9:0]};
  assign enc_bmp  = jsu_pkg::utf8_enc({5'b0, hex_new});
  assign enc_pair = jsu_pkg::utf8_enc(pair_cp);

  // next parser state
  always_comb begin
    mode_d = mode_q;
    hex_d  = hex_q;
    cnt_d  = cnt_q;
    high_d = high_q;
    if (text_end_i) begin
      if (mode_q != jsu_pkg::MODE_IDLE) begin
        mode_d = jsu_pkg::MODE_IDLE;
        hex_d  = '0;
        cnt_d  = '0;
      end
    end else begin
      case (mode_q)
        jsu_pkg::MODE_IDLE: begin
          if (in_byte_i == jsu_pkg::CH_QUOTE) mode_d = jsu_pkg::MODE_BODY;
        end
        jsu_pkg::MODE_BODY: begin
          if (in_byte_i == jsu_pkg::CH_QUOTE) mode_d = jsu_pkg::MODE_IDLE;
          else if (in_byte_i == jsu_pkg::CH_BSLASH) mode_d = jsu_pkg::MODE_ESC;
        end
        jsu_pkg::MODE_ESC: begin
          case (in_byte_i)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
            jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N,
            jsu_pkg::CH_R, jsu_pkg::CH_T: mode_d = jsu_pkg::MODE_BODY;
            jsu_pkg::CH_U: begin
              mode_d = jsu_pkg::MODE_HEX1;
              hex_d  = '0;
              cnt_d  = '0;
            end
            default: begin
              mode_d = jsu_pkg::MODE_IDLE;
              hex_d  = '0;
              cnt_d  = '0;
            end
          endcase
        end
        jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
          if (!hv[4]) begin
            mode_d = jsu_pkg::MODE_IDLE;
            hex_d  = '0;
            cnt_d  = '0;
          end else begin
            hex_d = hex_new;
            cnt_d = cnt_q + 2'd1;
            if (hex_done) begin
              if (mode_q == jsu_pkg::MODE_HEX1 && is_hi) begin
                mode_d = jsu_pkg::MODE_NEEDBS;
                high_d = hex_new[9:0];
              end else if ((mode_q == jsu_pkg::MODE_HEX1) ? is_lo : !is_lo) begin
                mode_d = jsu_pkg::MODE_IDLE;
                hex_d  = '0;
              end else begin
                mode_d = jsu_pkg::MODE_BODY;
              end
            end
          end
        end
        jsu_pkg::MODE_NEEDBS: begin
          mode_d = (in_byte_i == jsu_pkg::CH_BSLASH) ? jsu_pkg::MODE_NEEDU : jsu_pkg::MODE_IDLE;
          if (in_byte_i != jsu_pkg::CH_BSLASH) begin
            hex_d = '0;
            cnt_d = '0;
          end
        end
        jsu_pkg::MODE_NEEDU: begin
          mode_d = (in_byte_i == jsu_pkg::CH_U) ? jsu_pkg::MODE_HEX2 : jsu_pkg::MODE_IDLE;
          hex_d  = '0;
          cnt_d  = '0;
        end
        default: mode_d = jsu_pkg::MODE_IDLE;
      endcase
    end
  end

  // results of the accepted item
  always_comb begin
    res_num   = 3'd0;
    res_bytes = '0;
    res_kind  = jsu_pkg::KIND_DATA;
    if (text_end_i) begin
      if (mode_q != jsu_pkg::MODE_IDLE) begin
        res_num  = 3'd1;
        res_kind = jsu_pkg::KIND_ERR;
      end
    end else begin
      case (mode_q)
        jsu_pkg::MODE_BODY: begin
          if (in_byte_i == jsu_pkg::CH_QUOTE) begin
            res_num  = 3'd1;
            res_kind = jsu_pkg::KIND_OK;
          end else if (in_byte_i != jsu_pkg::CH_BSLASH) begin
            res_num      = 3'd1;
            res_bytes[0] = in_byte_i;
          end
        end
        jsu_pkg::MODE_ESC: begin
          res_num = 3'd1;
          case (in_byte_i)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH,
            jsu_pkg::CH_SLASH: res_bytes[0] = in_byte_i;
            jsu_pkg::CH_B:     res_bytes[0] = jsu_pkg::CTL_BS;
            jsu_pkg::CH_F:     res_bytes[0] = jsu_pkg::CTL_FF;
            jsu_pkg::CH_N:     res_bytes[0] = jsu_pkg::CTL_LF;
            jsu_pkg::CH_R:     res_bytes[0] = jsu_pkg::CTL_CR;
            jsu_pkg::CH_T:     res_bytes[0] = jsu_pkg::CTL_HT;
            jsu_pkg::CH_U:     res_num      = 3'd0;
            default:           res_kind     = jsu_pkg::KIND_ERR;
          endcase
        end
        jsu_pkg::MODE_HEX1: begin
          if (!hv[4] || (hex_done && is_lo)) begin
            res_num  = 3'd1;
            res_kind = jsu_pkg::KIND_ERR;
          end else if (hex_done && !is_hi) begin
            res_num   = enc_bmp.num;
            res_bytes = enc_bmp.bytes;
          end
        end
        jsu_pkg::MODE_HEX2: begin
          if (!hv[4] || (hex_done && !is_lo)) begin
            res_num  = 3'd1;
            res_kind = jsu_pkg::KIND_ERR;
          end else if (hex_done) begin
            res_num   = enc_pair.num;
            res_bytes = enc_pair.bytes;
          end
        end
        jsu_pkg::MODE_NEEDBS: begin
          if (in_byte_i != jsu_pkg::CH_BSLASH) begin
            res_num  = 3'd1;
            res_kind = jsu_pkg::KIND_ERR;
          end
        end
        jsu_pkg::MODE_NEEDU: begin
          if (in_byte_i != jsu_pkg::CH_U) begin
            res_num  = 3'd1;
            res_kind = jsu_pkg::KIND_ERR;
          end
        end
        default: res_num = 3'd0;
      endcase
    end
  end

  // result group: load on accept of an item with results, shift on take
  always_comb begin
    rem_d  = rem_q;
    byte_d = byte_q;
    kind_d = kind_q;
    if (out_take) begin
      rem_d  = rem_q - 3'd1;
      byte_d = {8'h00, byte_q[3:1]};
    end
    if (in_acc && res_num != 3'd0) begin
      rem_d  = res_num;
      byte_d = res_bytes;
      kind_d = res_kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_IDLE;
      hex_q  <= '0;
      cnt_q  <= '0;
      high_q <= '0;
      rem_q  <= '0;
    end else begin
      if (in_acc) begin
        mode_q <= mode_d;
        hex_q  <= hex_d;
        cnt_q  <= cnt_d;
        high_q <= high_d;
      end
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    kind_q <= kind_d;
  end

  assign out_valid_o = (rem_q != 3'd0);
  assign out_byte_o  = byte_q[0];
  assign kind_o      = kind_q;
  assign last_o      = (rem_q == 3'd1);

  `JSU_ASSERT_IMPL(a_status_alone, out_valid_o && kind_q != jsu_pkg::KIND_DATA, last_o)
  `JSU_ASSERT_IMPL(a_hold_input, rem_q > 3'd1, in_stall_o)
  `JSU_ASSERT_IMPL(a_free_input, rem_q == 3'd0, !in_stall_o)
  `JSU_ASSERT_NEXT(a_load_group, in_acc && res_num != 3'd0, rem_q == $past(res_num))

endmodule
